@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the clipper RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define LSSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssc assertion failed");
// next-cycle implication, disabled during reset
`define LSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssc assertion failed");
`else
`define LSSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/lssc_pkg.sv @@
// ----------------------------------------------------------------------------
// lssc_pkg
// Shared constants and types of the line segment screen clipper
// ----------------------------------------------------------------------------
package lssc_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 21;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 13;
    localparam int MAX_WIDTH       = CFG_DATA_WIDTH + 1;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // register reset values
    localparam logic [CFG_DATA_WIDTH-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_DATA_WIDTH-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // per-item control that rides along the divider stages
    typedef struct packed {
        logic neg;
        logic slide;
        logic clip;
    } clip_ctl_t;

endpackage

@@ rtl/lssc_clip_stage.sv @@
// ----------------------------------------------------------------------------
// lssc_clip_stage
// One clip of one endpoint against one pair of edges: decide, multiply,
// bit-serial restoring divide unrolled over stages, then slide and check; the
// clipped coordinate is pinned in the decide step
`include "assert_macros.svh"

module lssc_clip_stage #(
    parameter int COORD_WIDTH = lssc_pkg::COORD_WIDTH_DEF,
    parameter bit CLIP_Y      = 1'b0,
    parameter bit CLIP_END    = 1'b0
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic signed [lssc_pkg::MAX_WIDTH-1:0]   max_x,
    input  logic signed [lssc_pkg::MAX_WIDTH-1:0]   max_y,
    input  logic                                    in_valid,
    input  logic [4*COORD_WIDTH:0]                  in_seg,
    output logic                                    out_valid,
    output logic [4*COORD_WIDTH:0]                  out_seg
);

    localparam int W   = COORD_WIDTH;
    localparam int SW  = 4 * W + 1;
    localparam int CW  = W + 2;
    localparam int BW  = W + 1;
    localparam int PW  = 2 * W + 1;
    localparam int OKB = 4 * W;
    // coordinate slots: x1, y1, x2, y2
    localparam int C1I = (CLIP_END ? 2 : 0) + (CLIP_Y ? 1 : 0);
    localparam int O1I = C1I ^ 1;
    localparam int C2I = C1I ^ 2;
    localparam int O2I = C1I ^ 3;

    // decide stage
    logic signed [W-1:0]  c1, o1, c2, o2;
    logic signed [CW-1:0] c1e, o1e, c2e, o2e, maxc_e, maxx_e;
    logic signed [CW-1:0] a_val, b_val, d_val, a_abs, b_abs, d_abs;
    logic                 lo, hi, rej, act, ok_in;
    logic [SW-1:0]        d_seg_next;
    lssc_pkg::clip_ctl_t  d_ctl_next;

    logic                 d_valid_reg;
    logic [SW-1:0]        d_seg_reg;
    lssc_pkg::clip_ctl_t  d_ctl_reg;
    logic [W-1:0]         d_amag_reg;
    logic [BW-1:0]        d_bmag_reg;
    logic [BW-1:0]        d_dmag_reg;

    assign c1     = in_seg[C1I*W +: W];
    assign o1     = in_seg[O1I*W +: W];
    assign c2     = in_seg[C2I*W +: W];
    assign o2     = in_seg[O2I*W +: W];
    assign c1e    = CW'(c1);
    assign o1e    = CW'(o1);
    assign c2e    = CW'(c2);
    assign o2e    = CW'(o2);
    assign maxx_e = CW'(max_x);
    assign maxc_e = CLIP_Y ? CW'(max_y) : CW'(max_x);
    assign ok_in  = in_seg[OKB];

    always_comb
    begin
        lo    = c1e < 0;
        hi    = !lo && (c1e > maxc_e);
        rej   = !CLIP_END && ((lo && (c2e < 0)) || (hi && (c2e > maxc_e)));
        act   = ok_in && !rej && (lo || hi);
        a_val = lo ? c1e : c1e - maxc_e;
        b_val = o2e - o1e;
        d_val = c2e - c1e;
        a_abs = a_val[CW-1] ? -a_val : a_val;
        b_abs = b_val[CW-1] ? -b_val : b_val;
        d_abs = d_val[CW-1] ? -d_val : d_val;
        d_ctl_next.neg   = a_val[CW-1] ^ b_val[CW-1] ^ d_val[CW-1];
        d_ctl_next.slide = act && (d_val != 0);
        d_ctl_next.clip  = act;
        // pin the clipped coordinate and drop ok on an early reject
        d_seg_next       = in_seg;
        d_seg_next[OKB]  = ok_in && !rej;
        if (act)
        begin
            d_seg_next[C1I*W +: W] = lo ? '0 : maxc_e[W-1:0];
        end
    end

    // decide register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_seg_reg  <= d_seg_next;
            d_ctl_reg  <= d_ctl_next;
            d_amag_reg <= a_abs[W-1:0];
            d_bmag_reg <= b_abs[BW-1:0];
            d_dmag_reg <= d_abs[BW-1:0];
        end
    end

    // multiply and divider pipeline, index 0 holds the product
    logic [PW:0]         v_reg;
    logic [SW-1:0]       seg_reg  [PW+1];
    lssc_pkg::clip_ctl_t ctl_reg  [PW+1];
    logic [PW-1:0]       prod_reg [PW+1];
    logic [BW-1:0]       dmag_reg [PW+1];
    logic [BW-1:0]       rem_reg  [PW+1];
    logic [W-1:0]        quo_reg  [PW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PW-1:0], d_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg[0]  <= d_seg_reg;
            ctl_reg[0]  <= d_ctl_reg;
            prod_reg[0] <= PW'(d_amag_reg) * PW'(d_bmag_reg);
            dmag_reg[0] <= d_dmag_reg;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
        end
    end

    // one quotient bit per stage, only the low bits of the quotient are kept
    for (genvar k = 0; k < PW; k++)
    begin : g_div
        logic [BW:0]   sh;
        logic          ge;
        logic [BW-1:0] rem_next;
        logic [BW:0]   diff;

        assign sh       = {rem_reg[k], prod_reg[k][PW-1-k]};
        assign ge       = sh >= {1'b0, dmag_reg[k]};
        assign diff     = sh - {1'b0, dmag_reg[k]};
        assign rem_next = ge ? diff[BW-1:0] : sh[BW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                seg_reg[k+1]  <= seg_reg[k];
                ctl_reg[k+1]  <= ctl_reg[k];
                prod_reg[k+1] <= prod_reg[k];
                dmag_reg[k+1] <= dmag_reg[k];
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= {quo_reg[k][W-2:0], ge};
            end
        end
    end

    // finish: slide the other coordinate, check x after a y clip
    logic signed [W-1:0]  f_o1, q_signed, o1_new;
    logic signed [CW-1:0] o1_new_e;
    logic [SW-1:0]        out_seg_next;
    logic [SW-1:0]        f_seg;
    lssc_pkg::clip_ctl_t  f_ctl;

    assign f_seg    = seg_reg[PW];
    assign f_ctl    = ctl_reg[PW];
    assign f_o1     = f_seg[O1I*W +: W];
    assign q_signed = f_ctl.neg ? -signed'(quo_reg[PW]) : signed'(quo_reg[PW]);
    assign o1_new   = f_ctl.slide ? f_o1 - q_signed : f_o1;
    assign o1_new_e = CW'(o1_new);

    always_comb
    begin
        out_seg_next = f_seg;
        out_seg_next[O1I*W +: W] = o1_new;
        if (CLIP_Y && f_ctl.clip && ((o1_new_e < 0) || (o1_new_e > maxx_e)))
        begin
            out_seg_next[OKB] = 1'b0;
        end
    end

    logic          out_valid_reg;
    logic [SW-1:0] out_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_seg_reg <= out_seg_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_seg   = out_seg_reg;

    // checks
    `LSSC_ASSERT_IMPLY(a_slide_nonzero_div, clk, rst_n, d_valid_reg && d_ctl_reg.slide, d_dmag_reg != '0)
    `LSSC_ASSERT_IMPLY(a_rem_below_div, clk, rst_n, v_reg[PW] && f_ctl.slide, rem_reg[PW] < dmag_reg[PW])
    `LSSC_ASSERT_IMPLY(a_clip_pinned, clk, rst_n, v_reg[PW] && f_ctl.clip, (f_seg[C1I*W +: W] == '0) || (f_seg[C1I*W +: W] == maxc_e[W-1:0]))

endmodule

@@ rtl/line_segment_screen_clipper.sv @@
// Throughput: one segment per cycle unless the result side stalls; four clip units of
// 2*COORD_WIDTH+4 stages each, the bit-per-stage divider in each unit sets the depth.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads width 640 and height 480.
// ----------------------------------------------------------------------------
// line_segment_screen_clipper
// Clips a segment to the configured screen rectangle: start x, start y,
// end x, end y, with reject of segments that fall off screen
// ----------------------------------------------------------------------------
module line_segment_screen_clipper #(
    parameter int COORD_WIDTH = lssc_pkg::COORD_WIDTH_DEF,
    parameter int DATA_WIDTH  = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lssc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [lssc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // segment input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [DATA_WIDTH-1:0]                 s_tdata,  // start_x, start_y, end_x, end_y
    // clipped output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [DATA_WIDTH-1:0]                 m_tdata,  // clipped_start_x, clipped_start_y,
                                                            // clipped_end_x, clipped_end_y
    output logic                                  m_tuser   // visible
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = 4 * W + 1;

    // screen size registers
    logic [lssc_pkg::CFG_DATA_WIDTH-1:0] width_reg, height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lssc_pkg::SCREEN_WIDTH_RST;
            height_reg <= lssc_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lssc_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                lssc_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // right and bottom edges
    logic signed [lssc_pkg::MAX_WIDTH-1:0] max_x, max_y;

    assign max_x = signed'({1'b0, width_reg}) - lssc_pkg::MAX_WIDTH'(1);
    assign max_y = signed'({1'b0, height_reg}) - lssc_pkg::MAX_WIDTH'(1);

    // global advance: the whole pipeline moves unless the output beat is held
    logic en;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // four clips in sequence
    logic [3:0]    valid_w;
    logic [SW-1:0] seg_w [4];
    logic [SW-1:0] seg_in;

    assign seg_in = {1'b1, s_tdata[4*W-1:0]};

    lssc_clip_stage #(.COORD_WIDTH(W), .CLIP_Y(1'b0), .CLIP_END(1'b0)) u_start_x (
        .clk(clk), .rst_n(rst_n), .en(en), .max_x(max_x), .max_y(max_y),
        .in_valid(s_tvalid), .in_seg(seg_in),
        .out_valid(valid_w[0]), .out_seg(seg_w[0])
    );

    lssc_clip_stage #(.COORD_WIDTH(W), .CLIP_Y(1'b1), .CLIP_END(1'b0)) u_start_y (
        .clk(clk), .rst_n(rst_n), .en(en), .max_x(max_x), .max_y(max_y),
        .in_valid(valid_w[0]), .in_seg(seg_w[0]),
        .out_valid(valid_w[1]), .out_seg(seg_w[1])
    );

    lssc_clip_stage #(.COORD_WIDTH(W), .CLIP_Y(1'b0), .CLIP_END(1'b1)) u_end_x (
        .clk(clk), .rst_n(rst_n), .en(en), .max_x(max_x), .max_y(max_y),
        .in_valid(valid_w[1]), .in_seg(seg_w[1]),
        .out_valid(valid_w[2]), .out_seg(seg_w[2])
    );

    lssc_clip_stage #(.COORD_WIDTH(W), .CLIP_Y(1'b1), .CLIP_END(1'b1)) u_end_y (
        .clk(clk), .rst_n(rst_n), .en(en), .max_x(max_x), .max_y(max_y),
        .in_valid(valid_w[2]), .in_seg(seg_w[2]),
        .out_valid(valid_w[3]), .out_seg(seg_w[3])
    );

    // output beat
    assign m_tvalid = valid_w[3];
    assign m_tdata  = DATA_WIDTH'(seg_w[3][4*W-1:0]);
    assign m_tuser  = seg_w[3][4*W];

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// line segment screen clipper testbench
// Drives segments through the stream input and checks every clipped result
// against a cycle-free predictor or a typed row's result. Runs a directed table,
// then random segments over several screen sizes with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = lssc_pkg::COORD_WIDTH_DEF;
    localparam int DW         = ((4 * CW + 7) / 8) * 8;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 400;

    // index past the register list, the block ignores it
    localparam logic [lssc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd2;
    localparam logic [lssc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE  = 2'd3;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } segment_t;

    typedef struct {
        logic                 vis;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } clip_res_t;

    typedef struct {
        segment_t  seg;
        bit        typed;
        clip_res_t res;
    } stim_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [lssc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [lssc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [DW-1:0]                        s_tdata = '0;   // start_x, start_y, end_x, end_y
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [DW-1:0]                        m_tdata;        // clipped_start_x, clipped_start_y,
                                                          // clipped_end_x, clipped_end_y
    logic                                 m_tuser;        // visible

    // predictor copy of the screen registers
    longint    scr_width = lssc_pkg::SCREEN_WIDTH_RST;
    longint    scr_height = lssc_pkg::SCREEN_HEIGHT_RST;

    clip_res_t expected_clips[$];
    stim_row_t dir_rows[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        error_count = 0;
    int        segs_sent = 0;
    int        clips_checked = 0;
    int        visible_seen = 0;
    int        settings_used = 0;
    int        quiet_cycles = 0;

    line_segment_screen_clipper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hold a value in CW bits, two's complement
    function automatic longint wrap_coord(longint v);
        logic [63:0] t;
        t = v;
        return longint'({{(64-CW){t[CW-1]}}, t[CW-1:0]});
    endfunction

    function automatic longint unsigned mag_of(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // v - trunc(a * b / d), no slide on a zero divisor
    function automatic longint slide_coord(longint v, longint a, longint b, longint d);
        longint unsigned m;
        bit              neg;
        if (d == 0)
            return v;
        m   = mag_of(a) * mag_of(b) / mag_of(d);
        neg = ((a < 0) != (b < 0)) != (d < 0);
        return wrap_coord(neg ? v + longint'(m) : v - longint'(m));
    endfunction

    // clip in the order start x, start y, end x, end y
    function automatic clip_res_t clip_segment(segment_t s);
        clip_res_t r;
        longint    x1, y1, x2, y2, mx, my;
        bit        ok;
        x1 = s.sx;
        y1 = s.sy;
        x2 = s.ex;
        y2 = s.ey;
        mx = scr_width - 1;
        my = scr_height - 1;
        ok = 1'b0;
        do
        begin
            if (x1 < 0)
            begin
                if (x2 < 0) break;
                y1 = slide_coord(y1, x1, y2 - y1, x2 - x1);
                x1 = 0;
            end
            else if (x1 > mx)
            begin
                if (x2 > mx) break;
                y1 = slide_coord(y1, x1 - mx, y2 - y1, x2 - x1);
                x1 = wrap_coord(mx);
            end
            if (y1 < 0)
            begin
                if (y2 < 0) break;
                x1 = slide_coord(x1, y1, x2 - x1, y2 - y1);
                y1 = 0;
                if (x1 < 0 || x1 > mx) break;
            end
            else if (y1 > my)
            begin
                if (y2 > my) break;
                x1 = slide_coord(x1, y1 - my, x2 - x1, y2 - y1);
                y1 = wrap_coord(my);
                if (x1 < 0 || x1 > mx) break;
            end
            if (x2 < 0)
            begin
                y2 = slide_coord(y2, x2, y1 - y2, x1 - x2);
                x2 = 0;
            end
            else if (x2 > mx)
            begin
                y2 = slide_coord(y2, x2 - mx, y1 - y2, x1 - x2);
                x2 = wrap_coord(mx);
            end
            if (y2 < 0)
            begin
                x2 = slide_coord(x2, y2, x1 - x2, y1 - y2);
                y2 = 0;
                if (x2 < 0 || x2 > mx) break;
            end
            else if (y2 > my)
            begin
                x2 = slide_coord(x2, y2 - my, x1 - x2, y1 - y2);
                y2 = wrap_coord(my);
                if (x2 < 0 || x2 > mx) break;
            end
            ok = 1'b1;
        end
        while (0);
        r.vis = ok;
        r.sx  = x1[CW-1:0];
        r.sy  = y1[CW-1:0];
        r.ex  = x2[CW-1:0];
        r.ey  = y2[CW-1:0];
        return r;
    endfunction

    function automatic segment_t mk_seg(longint sx, longint sy, longint ex, longint ey);
        segment_t s;
        s.sx = sx[CW-1:0];
        s.sy = sy[CW-1:0];
        s.ex = ex[CW-1:0];
        s.ey = ey[CW-1:0];
        return s;
    endfunction

    // table row; a typed row carries its own expected result
    function automatic void add_row(segment_t s, bit typed = 1'b0, bit vis = 1'b0);
        stim_row_t row;
        row.seg       = s;
        row.typed     = typed;
        row.res.vis   = vis;
        row.res.sx    = s.sx;
        row.res.sy    = s.sy;
        row.res.ex    = s.ex;
        row.res.ey    = s.ey;
        dir_rows.push_back(row);
    endfunction

    // mostly near the screen, some full range, some extremes
    function automatic logic signed [CW-1:0] rand_coord(longint span);
        int     mode;
        longint v;
        mode = $urandom_range(0, 9);
        if (mode < 2)
        begin
            v = longint'($urandom);
            return v[CW-1:0];
        end
        if (mode == 2)
        begin
            case ($urandom_range(0, 3))
                0: return C_MIN;
                1: return C_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        v = longint'($urandom_range(0, 32'(3 * span))) - span;
        return v[CW-1:0];
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 clips_checked, field, got, want);
    endtask

    task automatic write_reg(logic [lssc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [lssc_pkg::CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == lssc_pkg::REG_SCREEN_WIDTH)
            scr_width = val;
        else if (idx == lssc_pkg::REG_SCREEN_HEIGHT)
            scr_height = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_screen(int w, int h);
        write_reg(lssc_pkg::REG_SCREEN_WIDTH, w[lssc_pkg::CFG_DATA_WIDTH-1:0]);
        write_reg(lssc_pkg::REG_SCREEN_HEIGHT, h[lssc_pkg::CFG_DATA_WIDTH-1:0]);
        settings_used++;
    endtask

    // one segment beat, with optional idle cycles before it
    task automatic send_segment(segment_t s, bit typed, clip_res_t typed_res);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'({s.ey, s.ex, s.sy, s.sx});
        do @(posedge clk); while (!s_tready);
        expected_clips.push_back(typed ? typed_res : clip_segment(s));
        segs_sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (expected_clips.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_phase(int n, int idle, int stall, bit pause_midway);
        segment_t  s;
        clip_res_t none;
        longint    span;
        none           = '{default: '0};
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        span = (scr_width > scr_height ? scr_width : scr_height) + 16;
        for (int i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
            begin
                s_tvalid <= 1'b0;
                while (expected_clips.size() != 0)
                    @(posedge clk);
            end
            s = mk_seg(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
            send_segment(s, 1'b0, none);
        end
        wait_results();
    endtask

    // result side: random stall, check each accepted beat
    always @(posedge clk)
    begin
        clip_res_t want;
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_clips.size() == 0)
            begin
                error_count++;
                $display("result beat with no segment outstanding");
            end
            else
            begin
                want = expected_clips.pop_front();
                if (m_tuser !== want.vis)
                    report_mismatch("visible", m_tuser, want.vis);
                if ($signed(m_tdata[CW-1:0]) !== want.sx)
                    report_mismatch("clipped_start_x", $signed(m_tdata[CW-1:0]), want.sx);
                if ($signed(m_tdata[2*CW-1:CW]) !== want.sy)
                    report_mismatch("clipped_start_y", $signed(m_tdata[2*CW-1:CW]), want.sy);
                if ($signed(m_tdata[3*CW-1:2*CW]) !== want.ex)
                    report_mismatch("clipped_end_x", $signed(m_tdata[3*CW-1:2*CW]), want.ex);
                if ($signed(m_tdata[4*CW-1:3*CW]) !== want.ey)
                    report_mismatch("clipped_end_y", $signed(m_tdata[4*CW-1:3*CW]), want.ey);
                if (m_tuser === 1'b1)
                    visible_seen++;
                clips_checked++;
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL line_segment_screen_clipper");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset screen of 640 x 480
        add_row(mk_seg(10, 20, 100, 200), 1'b1, 1'b1);
        add_row(mk_seg(0, 0, 639, 479), 1'b1, 1'b1);
        add_row(mk_seg(-5, 10, -7, 300), 1'b1, 1'b0);
        add_row(mk_seg(700, 10, 650, 300), 1'b1, 1'b0);
        add_row(mk_seg(10, -3, 300, -9), 1'b1, 1'b0);
        add_row(mk_seg(10, 500, 300, 480), 1'b1, 1'b0);
        add_row(mk_seg(C_MIN, C_MIN, C_MIN, C_MAX), 1'b1, 1'b0);
        add_row(mk_seg(C_MAX, 0, C_MAX, C_MAX), 1'b1, 1'b0);
        add_row(mk_seg(-100, 50, 100, 50));
        add_row(mk_seg(50, -100, 50, 100));
        add_row(mk_seg(700, 240, 320, 240));
        add_row(mk_seg(320, 600, 320, 240));
        add_row(mk_seg(320, 240, -50, 600));
        add_row(mk_seg(320, 240, 900, -20));
        add_row(mk_seg(-100, -100, 700, 700));
        add_row(mk_seg(-10, 470, 5, 520));
        add_row(mk_seg(C_MAX, C_MAX, C_MIN, C_MIN));
        add_row(mk_seg(C_MIN, C_MAX, C_MAX, C_MIN));
        add_row(mk_seg(0, 0, 0, 0));
        add_row(mk_seg(639, 479, 640, 480));
        foreach (dir_rows[i])
            send_segment(dir_rows[i].seg, dir_rows[i].typed, dir_rows[i].res);
        wait_results();

        // random phases over several screen sizes and idling mixes
        random_phase(150, 0, 0, 1'b0);
        set_screen(1, 1);
        write_reg(REG_UNUSED, 13'h1FFF);
        random_phase(100, 49, 0, 1'b0);
        set_screen(4096, 4096);
        write_reg(REG_SPARE, 13'd5);
        random_phase(150, 0, 49, 1'b0);
        set_screen(100, 37);
        random_phase(150, 31, 31, 1'b0);
        set_screen(0, 8191);
        random_phase(50, 0, 0, 1'b0);
        set_screen(8191, 0);
        random_phase(50, 31, 31, 1'b0);
        set_screen(320, 200);
        random_phase(200, 31, 31, 1'b1);

        $display("covered %0d segments over %0d screen settings, %0d results checked",
                 segs_sent, settings_used + 1, clips_checked);
        $display("%0d results came out visible", visible_seen);
        if (error_count == 0 && expected_clips.size() == 0)
            $display("PASS line_segment_screen_clipper");
        else
            $display("FAIL line_segment_screen_clipper");
        $finish;
    end
endmodule
